[src/mcg_pkg.sv]
// Shared types and constants of the metronome click generator.
package mcg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int FPB_W      = 20;
  localparam int BPB_W      = 5;
  localparam int TIER_W     = 5;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 40;
  localparam int BAR_W      = 25;
  localparam int LEN_W      = 13;
  localparam int IDX_W      = 12;
  localparam int OUT_W      = 16;
  localparam int MIX_W      = 20;
  localparam int AX_W       = 17;
  localparam int X2_W       = 34;
  localparam int ACOEF_W    = 36;
  localparam int DEN_W      = 37;
  localparam int NPART_W    = 35;
  localparam int NUM_W      = 53;
  localparam int DIVN_W     = 54;
  localparam int DIVD_W     = 38;
  localparam int DCNT_W     = 6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [ACOEF_W-1:0] PADE_A_Q30 = 36'd28991029248;  // 27 in Q30
  localparam logic signed [MIX_W-1:0] CLIP_HI = 20'sd98304;     // +3.0 in Q4.15
  localparam logic signed [MIX_W-1:0] CLIP_LO = -20'sd98304;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd32767;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sd32768;

  localparam logic [1:0] K_TICK    = 2'd0;
  localparam logic [1:0] K_PATTERN = 2'd1;
  localparam logic [1:0] K_ACCENT  = 2'd2;
  localparam logic [1:0] K_CLICK   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] R_FPB   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] R_BPB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] R_TIER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] R_AGAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] R_QGAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] R_EGAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] R_SGAIN = 3'd6;

  localparam logic [1:0] ROW_ACCENT    = 2'd0;
  localparam logic [1:0] ROW_QUARTER   = 2'd1;
  localparam logic [1:0] ROW_EIGHTH    = 2'd2;
  localparam logic [1:0] ROW_SIXTEENTH = 2'd3;

  localparam int TE_ACCENT = 0;
  localparam int TE_TRACK  = 4;

  typedef enum logic [2:0] {
    C_TICK, C_PAT, C_ACC, C_CLK, C_DROP
  } cls_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] index;
    logic [3:0]       beat;
    logic [1:0]       row;
    logic [1:0]       sub;
    logic [15:0]      sample;
    logic             last;
    logic             playing;
  } item_t;

  typedef struct packed {
    cls_t  cls;
    item_t item;
  } qent_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } fstat_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVN_W-1:0] quot;
    logic [DIVD_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BAR, S_MOD, S_MODW, S_WALK, S_VRD, S_VMUL, S_MIX, S_ABS,
    S_SQ, S_COEF, S_NLO, S_NHI, S_NSUM, S_DIV, S_DIVW, S_OUT
  } st_t;

endpackage

[src/mcg_front.sv]
// Input side: accepts items, classifies them and queues them for the back end.
module mcg_front import mcg_pkg::*; #(
  parameter int PATTERN_DEPTH = 64,
  parameter int SAMPLE_DEPTH  = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       kind,
  input  logic [IDX_W-1:0] index,
  input  logic [3:0]       beat_number,
  input  logic [1:0]       tier_row,
  input  logic [1:0]       subdivision,
  input  logic [15:0]      sample_value,
  input  logic             last,
  input  logic             playing,
  output logic             q_valid,
  output qent_t            q_entry,
  input  logic             q_pop,
  output fstat_t           fstat
);

  qent_t             qmem [QDEPTH];
  qent_t             ent_in;
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [31:0]       idx32;
  logic              push;

  assign idx32      = 32'(index);
  assign fstat.count = count;
  assign fstat.full  = (count == QCNT_W'(QDEPTH));
  assign in_stall   = fstat.full;
  assign push       = in_valid && !in_stall;
  assign q_valid    = (count != '0);
  assign q_entry    = qmem[rd_ptr];

  always_comb begin
    ent_in.item = '{kind: kind, index: index, beat: beat_number, row: tier_row,
                    sub: subdivision, sample: sample_value, last: last,
                    playing: playing};
    case (kind)
      K_TICK:    ent_in.cls = C_TICK;
      K_PATTERN: ent_in.cls = (idx32 < PATTERN_DEPTH) ? C_PAT : C_DROP;
      K_ACCENT:  ent_in.cls = (idx32 < SAMPLE_DEPTH) ? C_ACC : C_DROP;
      K_CLICK:   ent_in.cls = (idx32 < SAMPLE_DEPTH) ? C_CLK : C_DROP;
      default:   ent_in.cls = C_DROP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wr_ptr] <= ent_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

endmodule

[src/mcg_div.sv]
// Restoring divider, one quotient bit per cycle, shared by bar modulo and soft clip.
module mcg_div import mcg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVN_W-1:0] n;
  logic [DIVD_W-1:0] d;
  logic [DIVD_W-1:0] rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy, done;
  logic [DIVD_W:0]   trial;
  logic              qbit;

  assign trial = {rem, n[DIVN_W-1]};
  assign qbit  = (trial >= {1'b0, d});

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = n;
  assign rsp.rem  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIVN_W);
        n    <= req.dividend;
        d    <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? DIVD_W'(trial - {1'b0, d}) : trial[DIVD_W-1:0];
        n   <= {n[DIVN_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/mcg_back.sv]
// Back end: register file, pattern and sample memories, tick sequencer and output register.
module mcg_back import mcg_pkg::*; #(
  parameter int PATTERN_DEPTH = 64,
  parameter int SAMPLE_DEPTH  = 4096,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  qent_t                 q_entry,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [OUT_W-1:0] click_sample
);

  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int SAW = $clog2(SAMPLE_DEPTH);
  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = SW + GAIN_W + 1;

  // configuration
  logic [FPB_W-1:0]  fpb;
  logic [BPB_W-1:0]  bpb;
  logic [TIER_W-1:0] te;
  logic [GAIN_W-1:0] again, qgain, egain, sgain;

  always_ff @(posedge clk) begin
    if (rst) begin
      fpb   <= FPB_W'(24000);
      bpb   <= BPB_W'(4);
      te    <= TIER_W'(31);
      again <= GAIN_W'(32768);
      qgain <= GAIN_W'(32768);
      egain <= GAIN_W'(32768);
      sgain <= GAIN_W'(32768);
    end else if (cfg_write) begin
      case (cfg_index)
        R_FPB:   fpb   <= cfg_data;
        R_BPB:   bpb   <= cfg_data[BPB_W-1:0];
        R_TIER:  te    <= cfg_data[TIER_W-1:0];
        R_AGAIN: again <= cfg_data[GAIN_W-1:0];
        R_QGAIN: qgain <= cfg_data[GAIN_W-1:0];
        R_EGAIN: egain <= cfg_data[GAIN_W-1:0];
        R_SGAIN: sgain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  st_t state, state_next;

  item_t               cur;
  logic [POS_W-1:0]    fpos;
  logic [PCW-1:0]      pcount, iss;
  logic [LEN_W-1:0]    alen, clen, a_pos, c_pos;
  logic                a_act, c_act;
  logic [GAIN_W-1:0]   c_gain;
  logic [BAR_W-1:0]    bar, pib;
  logic                v1, v2;
  logic [7:0]          pat_q;
  logic [1:0]          row2;
  logic [FPB_W+6:0]    prod2;
  logic signed [SW-1:0] a_q, c_q;
  logic signed [PW-1:0] pa, pc;
  logic signed [MIX_W-1:0] mix;
  logic [AX_W-1:0]     ax;
  logic                neg;
  logic [X2_W-1:0]     x2;
  logic [ACOEF_W-1:0]  acoef;
  logic [DEN_W-1:0]    den;
  logic [NPART_W-1:0]  plo, phi;
  logic [NUM_W-1:0]    num;
  logic signed [OUT_W-1:0] res;

  logic                issue, walk_done, out_load, silent, hit;
  logic [31:0]         idx32;
  logic [SW+15:0]      s_ext;
  logic signed [SW-1:0] s_al;
  logic [6:0]          mulop;
  logic [AX_W-1:0]     qm, qneg;
  logic [BPB_W-1:0]    bpb_eff;

  assign idx32   = 32'(q_entry.item.index);
  assign s_ext   = {q_entry.item.sample, {SW{1'b0}}};
  assign s_al    = s_ext[SW+15:16];   // floor alignment of the 16-bit word
  assign issue   = (state == S_WALK) && (iss < pcount);
  assign walk_done = !issue && !v1 && !v2;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  assign silent  = !(q_entry.item.playing && te[TE_TRACK] && (pcount != '0));
  assign hit     = (prod2[FPB_W+6:2] == pib);
  assign qm      = div_rsp.quot[AX_W-1:0];
  assign qneg    = -qm;
  assign bpb_eff = (bpb == '0) ? BPB_W'(1) : bpb;
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_comb begin
    case (pat_q[3:2])
      ROW_EIGHTH:    mulop = {1'b0, pat_q[7:4], 2'b00} + {4'b0, pat_q[1:0], 1'b0};
      ROW_SIXTEENTH: mulop = {1'b0, pat_q[7:4], 2'b00} + {5'b0, pat_q[1:0]};
      default:       mulop = {1'b0, pat_q[7:4], 2'b00};
    endcase
  end

  // memories
  logic [7:0]    pat_mem [PATTERN_DEPTH];
  logic [SW-1:0] a_mem   [SAMPLE_DEPTH];
  logic [SW-1:0] c_mem   [SAMPLE_DEPTH];
  logic [31:0]   iss32, apos32, cpos32;

  assign iss32  = 32'(iss);
  assign apos32 = 32'(a_pos);
  assign cpos32 = 32'(c_pos);

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.cls == C_PAT)
      pat_mem[idx32[PAW-1:0]] <= {q_entry.item.beat, q_entry.item.row, q_entry.item.sub};
    pat_q <= pat_mem[iss32[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.cls == C_ACC) a_mem[idx32[SAW-1:0]] <= s_al;
    a_q <= a_mem[apos32[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.cls == C_CLK) c_mem[idx32[SAW-1:0]] <= s_al;
    c_q <= c_mem[cpos32[SAW-1:0]];
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIVN_W'(fpos);
    div_req.divisor  = DIVD_W'(bar);
    case (state)
      S_MOD: div_req.start = (bar != '0);
      S_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {num, 1'b0} + DIVN_W'(den);
        div_req.divisor  = {den, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (q_valid && q_entry.cls == C_TICK) state_next = silent ? S_OUT : S_BAR;
      S_BAR:  state_next = S_MOD;
      S_MOD:  state_next = (bar == '0) ? S_WALK : S_MODW;
      S_MODW: if (div_rsp.done) state_next = S_WALK;
      S_WALK: if (walk_done) state_next = S_VRD;
      S_VRD:  state_next = S_VMUL;
      S_VMUL: state_next = S_MIX;
      S_MIX:  state_next = S_ABS;
      S_ABS:  state_next = (mix > CLIP_HI || mix < CLIP_LO) ? S_OUT : S_SQ;
      S_SQ:   state_next = S_COEF;
      S_COEF: state_next = S_NLO;
      S_NLO:  state_next = S_NHI;
      S_NHI:  state_next = S_NSUM;
      S_NSUM: state_next = S_DIV;
      S_DIV:  state_next = S_DIVW;
      S_DIVW: if (div_rsp.done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fpos      <= '0;
      pcount    <= '0;
      alen      <= '0;
      clen      <= '0;
      a_pos     <= '0;
      c_pos     <= '0;
      a_act     <= 1'b0;
      c_act     <= 1'b0;
      c_gain    <= '0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      iss       <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (issue) iss <= iss + 1'b1;
      if (v1) begin
        prod2 <= mulop * fpb;
        row2  <= pat_q[3:2];
      end
      if (out_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE:
          if (q_valid) begin
            cur <= q_entry.item;
            case (q_entry.cls)
              C_PAT: if (q_entry.item.last) pcount <= PCW'(idx32 + 32'd1);
              C_ACC:
                if (q_entry.item.last) begin
                  alen  <= LEN_W'(idx32 + 32'd1);
                  a_act <= 1'b0;
                end
              C_CLK:
                if (q_entry.item.last) begin
                  clen  <= LEN_W'(idx32 + 32'd1);
                  c_act <= 1'b0;
                end
              C_TICK:
                if (silent) begin
                  a_act <= 1'b0;
                  c_act <= 1'b0;
                  res   <= '0;
                end
              default: ;
            endcase
          end
        S_BAR: bar <= fpb * bpb_eff;
        S_MOD: begin
          iss <= '0;
          pib <= '0;
        end
        S_MODW: if (div_rsp.done) pib <= div_rsp.rem[BAR_W-1:0];
        S_WALK:
          if (v2 && hit) begin
            if (row2 == ROW_ACCENT) begin
              if (te[TE_ACCENT] && alen != '0) begin
                a_act <= 1'b1;
                a_pos <= '0;
              end
            end else if (te[{1'b0, row2}] && clen != '0) begin
              c_act <= 1'b1;
              c_pos <= '0;
              case (row2)
                ROW_QUARTER: c_gain <= qgain;
                ROW_EIGHTH:  c_gain <= egain;
                default:     c_gain <= sgain;
              endcase
            end
          end
        S_VMUL: begin
          if (a_act) pa <= $signed(a_q) * $signed({1'b0, again});
          else       pa <= '0;
          if (c_act) pc <= $signed(c_q) * $signed({1'b0, c_gain});
          else       pc <= '0;
          if (a_act) begin
            a_pos <= a_pos + 1'b1;
            if (a_pos + 1'b1 >= alen) a_act <= 1'b0;
          end
          if (c_act) begin
            c_pos <= c_pos + 1'b1;
            if (c_pos + 1'b1 >= clen) c_act <= 1'b0;
          end
        end
        S_MIX: mix <= MIX_W'(pa >>> (SW - 1)) + MIX_W'(pc >>> (SW - 1));
        S_ABS: begin
          if (mix > CLIP_HI)      res <= OUT_MAX;
          else if (mix < CLIP_LO) res <= OUT_MIN;
          ax  <= mix[MIX_W-1] ? AX_W'(-mix) : AX_W'(mix);
          neg <= mix[MIX_W-1];
        end
        S_SQ: x2 <= ax * ax;
        S_COEF: begin
          acoef <= PADE_A_Q30 + ACOEF_W'(x2);
          den   <= DEN_W'(PADE_A_Q30) + DEN_W'({x2, 3'b000}) + DEN_W'(x2);
        end
        S_NLO: plo <= ax * acoef[17:0];
        S_NHI: phi <= ax * acoef[35:18];
        S_NSUM: num <= NUM_W'(plo) + {phi, 18'b0};
        S_DIVW:
          if (div_rsp.done) begin
            if (neg)                        res <= qneg[OUT_W-1:0];
            else if (qm > AX_W'(32767))     res <= OUT_MAX;
            else                            res <= qm[OUT_W-1:0];
          end
        S_OUT:
          if (out_load) begin
            click_sample <= res;
            if (cur.playing) fpos <= fpos + 1'b1;
          end
        default: ;
      endcase
    end
  end

endmodule

[src/metronome_click_generator_unit.sv]
// Top level of the metronome click generator: input queue, sequencer and divider.
// Write items (pattern entries, accent and click sample words) are stored by the back end
// as they leave the queue. A tick with the transport stopped, the click track disabled or an
// empty pattern yields 0 and goes straight to the output load. A running tick goes through
// dequeue and bar length, the bar-position modulo in the shared bit-serial divider, a
// pipelined walk over the pattern memory, the voice read and multiply, the mix, the Pade
// multiply steps, the soft-clip division in the same divider and the output load. A zero
// bar length skips the modulo; a mix that clips hard beyond +-3 skips the Pade steps
// and the division. A stalled output holds the result until the output register is free.
// A four-entry queue takes items while the back end works and a result waits.
module metronome_click_generator_unit import mcg_pkg::*; #(
  parameter int PATTERN_DEPTH = 64,
  parameter int SAMPLE_DEPTH  = 4096,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [IDX_W-1:0]      index,
  input  logic [3:0]            beat_number,
  input  logic [1:0]            tier_row,
  input  logic [1:0]            subdivision,
  input  logic signed [15:0]    sample_value,
  input  logic                  last,
  input  logic                  playing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [OUT_W-1:0] click_sample
);

  logic     q_valid, q_pop;
  qent_t    q_entry;
  fstat_t   fstat;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mcg_front #(
    .PATTERN_DEPTH(PATTERN_DEPTH),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .index, .beat_number, .tier_row,
    .subdivision, .sample_value, .last, .playing,
    .q_valid, .q_entry, .q_pop, .fstat
  );

  mcg_div u_div (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

  mcg_back #(
    .PATTERN_DEPTH(PATTERN_DEPTH),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .q_valid, .q_entry, .q_pop, .div_req, .div_rsp,
    .out_valid, .out_stall, .click_sample
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.count <= QCNT_W'(QDEPTH))
    else $error("input queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end pops an empty queue");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

[test/click_checker.sv]
// Watches the click generator ports, predicts each tick's output sample and compares.
module click_checker import mcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            kind,
  input  logic [IDX_W-1:0]      index,
  input  logic [3:0]            beat_number,
  input  logic [1:0]            tier_row,
  input  logic [1:0]            subdivision,
  input  logic signed [15:0]    sample_value,
  input  logic                  last,
  input  logic                  playing,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic signed [OUT_W-1:0] click_sample,
  output int                    errors,
  output int                    pending
);

  localparam bit V_ACC = 1'b0;
  localparam bit V_CLK = 1'b1;

  logic [FPB_W-1:0]  fpb;
  logic [BPB_W-1:0]  bpb;
  logic [TIER_W-1:0] tiers;
  logic [GAIN_W-1:0] gain_acc, gain_q, gain_e, gain_s, click_gain;
  logic [POS_W-1:0]  frame_pos;
  logic [7:0]        pat_mem [64];
  int                pat_count;
  logic signed [15:0] smem [2][4096];
  int                vlen [2];
  int                vrd [2];
  bit                von [2];
  logic signed [15:0] expected_samples [$];

  function automatic longint scale_voice(logic signed [15:0] s, logic [GAIN_W-1:0] g);
    longint p;
    p = longint'(s) * longint'({1'b0, g});
    return p >>> 15;
  endfunction

  function automatic logic signed [15:0] pade_clip(longint x);
    longint ax, x2, num, den, q;
    if (x > 98304) return 16'sd32767;
    if (x < -98304) return -16'sd32768;
    ax = (x < 0) ? -x : x;
    x2 = ax * ax;
    num = ax * ((longint'(27) << 30) + x2);
    den = (longint'(27) << 30) + 9 * x2;
    q = (2 * num + den) / (2 * den);
    if (x < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // advance one voice by a frame, returns its Q4.15 contribution
  function automatic longint play_voice(bit v, logic [GAIN_W-1:0] g);
    longint r;
    r = 0;
    if (!von[v]) return 0;
    if (vrd[v] < vlen[v]) r = scale_voice(smem[v][12'(vrd[v])], g);
    vrd[v]++;
    if (vrd[v] >= vlen[v]) von[v] = 0;
    return r;
  endfunction

  function automatic void tick_frame(bit run);
    longint unsigned bar, posb, ef;
    logic [7:0] e;
    logic [1:0] er, es;
    int k;
    longint mix;
    if (run && tiers[TE_TRACK] && pat_count > 0) begin
      bar = longint'(fpb) * ((bpb != 0) ? longint'(bpb) : 1);
      posb = (bar != 0) ? longint'(frame_pos) % bar : 0;
      for (int i = 0; i < pat_count; i++) begin
        e = pat_mem[6'(i)];
        er = e[3:2];
        es = e[1:0];
        k = (er == ROW_EIGHTH) ? 2 : (er == ROW_SIXTEENTH) ? 1 : 0;
        ef = ((longint'(e[7:4]) * 4 + longint'(es) * k) * longint'(fpb)) >> 2;
        if (ef != posb) continue;
        if (er == ROW_ACCENT) begin
          if (tiers[TE_ACCENT] && vlen[V_ACC] > 0) begin
            von[V_ACC] = 1;
            vrd[V_ACC] = 0;
          end
        end else if (tiers[{1'b0, er}] && vlen[V_CLK] > 0) begin
          von[V_CLK] = 1;
          vrd[V_CLK] = 0;
          click_gain = (er == ROW_QUARTER) ? gain_q : (er == ROW_EIGHTH) ? gain_e : gain_s;
        end
      end
      mix = play_voice(V_ACC, gain_acc);
      mix += play_voice(V_CLK, click_gain);
      expected_samples = {expected_samples, pade_clip(mix)};
    end else begin
      von[V_ACC] = 0;
      von[V_CLK] = 0;
      expected_samples = {expected_samples, 16'sd0};
    end
    if (run) frame_pos = frame_pos + 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fpb = 20'd24000;
      bpb = 5'd4;
      tiers = 5'd31;
      gain_acc = 16'd32768;
      gain_q = 16'd32768;
      gain_e = 16'd32768;
      gain_s = 16'd32768;
      click_gain = '0;
      frame_pos = '0;
      pat_count = 0;
      vlen = '{0, 0};
      vrd = '{0, 0};
      von = '{0, 0};
      expected_samples.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          R_FPB:   fpb = cfg_data[FPB_W-1:0];
          R_BPB:   bpb = cfg_data[BPB_W-1:0];
          R_TIER:  tiers = cfg_data[TIER_W-1:0];
          R_AGAIN: gain_acc = cfg_data[GAIN_W-1:0];
          R_QGAIN: gain_q = cfg_data[GAIN_W-1:0];
          R_EGAIN: gain_e = cfg_data[GAIN_W-1:0];
          R_SGAIN: gain_s = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer: %0d", click_sample);
        end else begin
          if (click_sample !== expected_samples[0]) begin
            errors++;
            if (errors <= 10)
              $display("click_sample mismatch: expected %0d actual %0d",
                       expected_samples[0], click_sample);
          end
          void'(expected_samples.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        case (kind)
          K_TICK: tick_frame(playing);
          K_PATTERN: if (index < 64) begin
            pat_mem[index[5:0]] = {beat_number, tier_row, subdivision};
            if (last) pat_count = index + 1;
          end
          default: begin
            smem[(kind == K_ACCENT) ? V_ACC : V_CLK][index] = sample_value;
            if (last) begin
              vlen[(kind == K_ACCENT) ? V_ACC : V_CLK] = index + 1;
              von[(kind == K_ACCENT) ? V_ACC : V_CLK] = 0;
            end
          end
        endcase
      end
    end
    pending = expected_samples.size();
  end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the metronome click generator.
module testbench;
  import mcg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [IDX_W-1:0] index = '0;
  logic [3:0] beat_number = '0;
  logic [1:0] tier_row = '0;
  logic [1:0] subdivision = '0;
  logic signed [15:0] sample_value = '0;
  logic last = 0;
  logic playing = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OUT_W-1:0] click_sample;
  int errors, pending;

  bit quiet = 0;
  bit hold_start = 0;
  int hold_cnt = 0;
  int stall_left = 0;
  int items_sent = 0;
  int pat_fill = 0, acc_fill = 0, clk_fill = 0;
  int cur_bpb = 4;

  always #10 clk = ~clk;

  metronome_click_generator_unit dut (.*);
  click_checker chk (.*);

  // receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_start && hold_cnt < 3000) begin
      out_stall <= 1;
      hold_cnt++;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send(logic [1:0] k, logic [IDX_W-1:0] idx, logic [3:0] b, logic [1:0] r,
                      logic [1:0] s, logic [15:0] v, logic l, logic p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    index <= idx;
    beat_number <= b;
    tier_row <= r;
    subdivision <= s;
    sample_value <= v;
    last <= l;
    playing <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // keep track of how far each store is written contiguously from zero
    if (k == K_PATTERN && idx == pat_fill) pat_fill++;
    if (k == K_ACCENT && idx == acc_fill) acc_fill++;
    if (k == K_CLICK && idx == clk_fill) clk_fill++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_regs(logic [19:0] fpb, logic [19:0] bpb, logic [19:0] te,
                            logic [19:0] ga, logic [19:0] gq, logic [19:0] ge,
                            logic [19:0] gs);
    logic [19:0] vals [7];
    vals = '{fpb, bpb, te, ga, gq, ge, gs};
    cur_bpb = (bpb[4:0] == 0) ? 1 : bpb[4:0];
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[3'(i)];
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  function automatic logic [3:0] pick_beat();
    if ($urandom_range(0, 7) == 0) return 4'($urandom);
    return 4'($urandom_range(0, (cur_bpb > 16 ? 16 : cur_bpb) - 1));
  endfunction

  task automatic load_pattern(int n);
    for (int i = 0; i < n; i++)
      send(K_PATTERN, IDX_W'(i), pick_beat(), 2'($urandom), 2'($urandom), 16'($urandom),
           i == n - 1, 1'($urandom));
  endtask

  task automatic load_samples(logic [1:0] k, int n);
    for (int i = 0; i < n; i++)
      send(k, IDX_W'(i), 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
           i == n - 1, 1'($urandom));
  endtask

  task automatic random_item();
    int r, idx;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      send(K_TICK, 12'($urandom), 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
           1'($urandom), $urandom_range(0, 9) != 0);
    end else if (r < 78) begin
      idx = $urandom_range(0, (pat_fill < 63) ? pat_fill : 63);
      send(K_PATTERN, IDX_W'(idx), pick_beat(), 2'($urandom), 2'($urandom), 16'($urandom),
           $urandom_range(0, 3) == 0, 1'($urandom));
    end else if (r < 82) begin
      // beyond the table, dropped by the block
      send(K_PATTERN, 12'($urandom_range(64, 4095)), 4'($urandom), 2'($urandom),
           2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    end else if (r < 88) begin
      idx = $urandom_range(0, (acc_fill < 40) ? acc_fill : 40);
      send(K_ACCENT, IDX_W'(idx), 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
           $urandom_range(0, 3) == 0, 1'($urandom));
    end else if (r < 94) begin
      idx = $urandom_range(0, (clk_fill < 40) ? clk_fill : 40);
      send(K_CLICK, IDX_W'(idx), 4'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
           $urandom_range(0, 3) == 0, 1'($urandom));
    end else begin
      send($urandom_range(0, 1) ? K_ACCENT : K_CLICK, 12'($urandom), 4'($urandom),
           2'($urandom), 2'($urandom), 16'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every row, subdivisions 0, 1 and 3, empty-sample trigger, extremes, ignored writes
    write_regs(20'd4, 20'd2, 20'd31, 20'd65535, 20'd32768, 20'd65535, 20'd16384);
    send(K_PATTERN, 0, 4'd0, ROW_ACCENT, 2'd0, 16'sd0, 1'b0, 1'b0);
    send(K_PATTERN, 1, 4'd0, ROW_QUARTER, 2'd0, 16'sd0, 1'b0, 1'b0);
    send(K_PATTERN, 2, 4'd1, ROW_EIGHTH, 2'd1, 16'sd0, 1'b0, 1'b0);
    send(K_PATTERN, 3, 4'd1, ROW_SIXTEENTH, 2'd3, 16'sd0, 1'b0, 1'b0);
    send(K_PATTERN, 4, 4'd15, ROW_SIXTEENTH, 2'd1, 16'sd0, 1'b1, 1'b0);
    send(K_TICK, 0, 0, 0, 0, 0, 0, 1'b1);
    send(K_TICK, 0, 0, 0, 0, 0, 0, 1'b1);
    send(K_PATTERN, 12'd4095, 4'd15, 2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1);
    send(K_ACCENT, 0, 0, 0, 0, 16'sd32767, 1'b0, 0);
    send(K_ACCENT, 1, 0, 0, 0, -16'sd32768, 1'b0, 0);
    send(K_ACCENT, 2, 0, 0, 0, 16'sd0, 1'b1, 0);
    send(K_CLICK, 0, 0, 0, 0, 16'sd32767, 1'b0, 0);
    send(K_CLICK, 1, 0, 0, 0, -16'sd32768, 1'b0, 0);
    send(K_CLICK, 2, 0, 0, 0, 16'sd12345, 1'b1, 0);
    send(K_CLICK, 12'd4095, 0, 0, 0, -16'sd1, 1'b0, 0);
    repeat (8) send(K_TICK, 0, 0, 0, 0, 0, 0, 1'b1);
    send(K_TICK, 0, 0, 0, 0, 0, 0, 1'b0);

    phase = 0;
    while (items_sent < 1050) begin
      drain();
      case (phase)
        0: write_regs(20'hFFFFF, 20'd31, 20'd31, 20'd65535, 20'd65535, 20'd65535, 20'd65535);
        1: write_regs(20'd0, 20'd0, 20'd31, 20'd0, 20'd0, 20'd0, 20'd0);
        2: write_regs(20'd3, 20'd16, 20'd0, 20'd40000, 20'd1, 20'd65535, 20'd0);
        3: write_regs(20'd0, 20'd1, 20'd31, 20'd65535, 20'd65535, 20'd65535, 20'd65535);
        default: write_regs(20'($urandom_range(1, 6)), 20'($urandom_range(1, 5)),
                            $urandom_range(0, 3) ? 20'(5'h10 | 5'($urandom))
                                                 : 20'(5'($urandom)),
                            20'(16'($urandom)), 20'(16'($urandom)), 20'(16'($urandom)),
                            20'(16'($urandom)));
      endcase
      if (items_sent > 800) quiet = 1;
      load_pattern((phase == 4) ? 64 : $urandom_range(1, 8));
      load_samples(K_ACCENT, $urandom_range(1, 20));
      load_samples(K_CLICK, $urandom_range(1, 20));
      if (phase == 5) hold_start = 1;
      repeat (100) random_item();
      phase++;
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[metronome_click_generator_unit.f]
src/mcg_pkg.sv
src/mcg_front.sv
src/mcg_div.sv
src/mcg_back.sv
src/metronome_click_generator_unit.sv
test/click_checker.sv
test/testbench.sv
